[hdl/fct_pkg.sv]
package fct_pkg;

   localparam int OPERAND_W = 12;
   localparam int KIND_W    = 2;

   // request kind codes as they arrive on req_tuser
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd2;

   // classified operation handed from front to back
   typedef enum logic [1:0] {
      OP_INSERT,
      OP_DELETE,
      OP_CHECK
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic                   never_hit;  // check of zero or above max count
      logic [OPERAND_W-1:0]   operand;
   } item_type;

endpackage

[hdl/fct_ram.sv]
module fct_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/fct_front.sv]
module fct_front import fct_pkg::*; #(
   parameter int KEY_SPACE = 4096,
   parameter int COUNT_MAX = 4095
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [KIND_W-1:0]    req_kind,
   input  logic [OPERAND_W-1:0] req_operand,
   input  logic                 clear_busy,
   output logic                 q_valid,
   output item_type             q_item,
   input  logic                 q_pop
);

   item_type   fifo_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       accept, keep, push;
   item_type   cls;

   // classify: drop out-of-range keys and the unused kind
   always_comb begin
      cls.operand   = req_operand;
      cls.never_hit = (req_operand == '0) || (32'(req_operand) > COUNT_MAX);
      cls.op        = OP_CHECK;
      keep          = 1'b0;
      case (req_kind)
         KIND_INSERT: begin
            cls.op = OP_INSERT;
            keep   = 32'(req_operand) < KEY_SPACE;
         end
         KIND_DELETE: begin
            cls.op = OP_DELETE;
            keep   = 32'(req_operand) < KEY_SPACE;
         end
         KIND_CHECK: begin
            cls.op = OP_CHECK;
            keep   = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_tready = !clear_busy && (cnt_ff != 2'd2);
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && keep;
   assign q_valid    = cnt_ff != 2'd0;
   assign q_item     = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
         if (push) begin
            fifo_ff[wr_ptr_ff] <= cls;
         end
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count overflow");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_no_take_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !push) else $error("request queued during clear");

endmodule

[hdl/fct_back.sv]
module fct_back import fct_pkg::*; #(
   parameter int KEY_SPACE = 4096,
   parameter int COUNT_MAX = 4095
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  item_type q_item,
   output logic     q_pop,
   output logic     clear_busy,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output logic     rsp_present
);

   localparam int KW    = $clog2(KEY_SPACE);
   localparam int HD    = COUNT_MAX + 1;
   localparam int CW    = $clog2(HD);
   localparam int HW    = $clog2(KEY_SPACE + 1);
   localparam int CLR_N = (KEY_SPACE > HD) ? KEY_SPACE : HD;
   localparam int CLRW  = $clog2(CLR_N + 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_KEY,
      ST_HOLD,
      ST_HNEW,
      ST_CHECK
   } state_type;

   state_type       state_ff, state_in;
   logic [CLRW-1:0] clr_ff, clr_in;
   op_type          op_ff, op_in;
   logic [KW-1:0]   key_ff, key_in;
   logic [CW-1:0]   freq_ff, freq_in;
   logic            never_ff, never_in;
   logic [CW-1:0]   old_ff, old_in;
   logic [CW-1:0]   new_ff, new_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_present_ff, rsp_present_in;

   logic            key_we, hist_we;
   logic [KW-1:0]   key_waddr, key_raddr;
   logic [CW-1:0]   key_wdata, key_rdata;
   logic [CW-1:0]   hist_waddr, hist_raddr;
   logic [HW-1:0]   hist_wdata, hist_rdata;
   logic            is_ins, change, load_rsp;
   logic [CW-1:0]   new_cnt;

   fct_ram #(.WIDTH(CW), .DEPTH(KEY_SPACE)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_addr (key_raddr),
      .rd_data (key_rdata)
   );

   fct_ram #(.WIDTH(HW), .DEPTH(HD)) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_addr (hist_raddr),
      .rd_data (hist_rdata)
   );

   // old count is valid in ST_KEY
   assign is_ins  = op_ff == OP_INSERT;
   assign change  = is_ins ? (key_rdata < CW'(COUNT_MAX)) : (key_rdata != '0);
   assign new_cnt = is_ins ? CW'(key_rdata + 1'b1) : CW'(key_rdata - 1'b1);

   assign clear_busy = state_ff == ST_CLEAR;
   assign q_pop      = (state_ff == ST_IDLE) && q_valid;
   assign load_rsp   = (state_ff == ST_CHECK) && (!rsp_valid_ff || rsp_tready);

   // memory ports
   always_comb begin
      key_we     = 1'b0;
      key_waddr  = key_ff;
      key_wdata  = new_cnt;
      key_raddr  = key_ff;
      hist_we    = 1'b0;
      hist_waddr = new_ff;
      hist_wdata = HW'(hist_rdata + 1'b1);
      hist_raddr = old_ff;
      case (state_ff)
         ST_CLEAR: begin
            key_we     = clr_ff < CLRW'(KEY_SPACE);
            key_waddr  = KW'(clr_ff);
            key_wdata  = '0;
            hist_we    = clr_ff < CLRW'(HD);
            hist_waddr = CW'(clr_ff);
            hist_wdata = '0;
         end
         ST_IDLE: begin
            key_raddr  = KW'(q_item.operand);
            hist_raddr = CW'(q_item.operand);
         end
         ST_KEY: begin
            key_we     = change;
            hist_raddr = key_rdata;
         end
         ST_HOLD: begin
            hist_we    = (old_ff != '0) && (hist_rdata != '0);
            hist_waddr = old_ff;
            hist_wdata = HW'(hist_rdata - 1'b1);
            hist_raddr = new_ff;
         end
         ST_HNEW: begin
            hist_we = new_ff != '0;
         end
         ST_CHECK: begin
            hist_raddr = freq_ff;
         end
         default: begin
            key_we  = 1'b0;
            hist_we = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      freq_in        = freq_ff;
      never_in       = never_ff;
      old_in         = old_ff;
      new_in         = new_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_present_in = rsp_present_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = CLRW'(clr_ff + 1'b1);
            if (clr_ff == CLRW'(CLR_N - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               op_in    = q_item.op;
               key_in   = KW'(q_item.operand);
               freq_in  = CW'(q_item.operand);
               never_in = q_item.never_hit;
               state_in = (q_item.op == OP_CHECK) ? ST_CHECK : ST_KEY;
            end
         end
         ST_KEY: begin
            old_in   = key_rdata;
            new_in   = new_cnt;
            state_in = change ? ST_HOLD : ST_IDLE;
         end
         ST_HOLD: begin
            state_in = ST_HNEW;
         end
         ST_HNEW: begin
            state_in = ST_IDLE;
         end
         ST_CHECK: begin
            if (load_rsp) begin
               rsp_valid_in   = 1'b1;
               rsp_present_in = !never_ff && (hist_rdata != '0);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         rsp_valid_ff   <= rsp_valid_in;
         op_ff          <= op_in;
         key_ff         <= key_in;
         freq_ff        <= freq_in;
         never_ff       <= never_in;
         old_ff         <= old_in;
         new_ff         <= new_in;
         rsp_present_ff <= rsp_present_in;
      end
   end

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_present = rsp_present_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_present_ff)))
      else $error("pending response lost");
   a_hnew_after_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HNEW) |-> $past(state_ff == ST_HOLD))
      else $error("histogram increment out of order");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE)) else $error("pop while busy");
   a_key_wr_once: assert property (@(posedge clock) disable iff (reset)
      (key_we && state_ff == ST_KEY) |=> (state_ff == ST_HOLD))
      else $error("key write without histogram update");

endmodule

[hdl/frequency_count_table_core.sv]
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  tuser: kind; tdata: operand (key or frequency)
// rsp_      out  rsp_tvalid/rsp_tready  tdata: present (checks only)
//
// Insert/delete from queue head: key read, histogram read of old count,
// histogram read of new count, last write; a saturated or empty key ends
// after the key read. Check: one histogram read. Single-read-port RAMs
// force these steps into sequence. After reset a clearing pass over
// max(KEY_SPACE, COUNT_MAX+1) addresses zeroes both memories; req_tready
// stays low meanwhile. A two-entry request queue keeps req_ open while the
// back end works or the response register waits on rsp_tready.
module frequency_count_table_core import fct_pkg::*; #(
   parameter int KEY_SPACE = 4096,
   parameter int COUNT_MAX = 4095
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [11:0] operand, [15:12] zero
   input  logic [1:0]  req_tuser,   // [1:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [0] present, [7:1] zero
);

   logic     q_valid;
   item_type q_item;
   logic     q_pop;
   logic     clear_busy;
   logic     present;

   // front end: classification and request queue
   fct_front #(.KEY_SPACE(KEY_SPACE), .COUNT_MAX(COUNT_MAX)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_kind    (req_tuser),
      .req_operand (req_tdata[OPERAND_W-1:0]),
      .clear_busy  (clear_busy),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   // back end: count and histogram update, check lookups, response register
   fct_back #(.KEY_SPACE(KEY_SPACE), .COUNT_MAX(COUNT_MAX)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .clear_busy  (clear_busy),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_present (present)
   );

   assign rsp_tdata = {7'd0, present};

endmodule

[test/tb.sv]
`default_nettype none

module tb import fct_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEY_SPACE = 4096;
   localparam int COUNT_MAX = 4095;
   localparam int RANDOM_REQS = 1500;
   localparam int IDLE_PCT = 28;
   localparam int POOL_SIZE = 16;
   localparam int PLAN_ROWS = 24;
   // kind 3 has no meaning; the core must drop it without a response
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [15:0] req_tdata;   // [11:0] operand, [15:12] zero
   logic [1:0] req_tuser;    // [1:0] kind
   logic rsp_tvalid;
   logic rsp_tready;
   logic [7:0] rsp_tdata;    // [0] present, [7:1] zero

   frequency_count_table_core #(
      .KEY_SPACE(KEY_SPACE),
      .COUNT_MAX(COUNT_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   // one directed row: a request sent reps times; on checks, either a typed
   // answer or the shadow table's answer
   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [OPERAND_W-1:0] operand;
      logic [12:0]          reps;
      logic                 typed;
      logic                 present;
   } plan_row_type;

   plan_row_type plan [PLAN_ROWS];

   // shadow of both stores in the core
   logic [OPERAND_W-1:0] key_count [KEY_SPACE];
   int unsigned keys_at_count [COUNT_MAX+1];

   // answers owed on rsp_, oldest first
   bit pending_present [$];

   bit calm;            // suppresses idling on both sides
   int errors;
   int n_insert, n_delete, n_check, n_ignored, n_hits, n_answered;
   logic [OPERAND_W-1:0] key_pool [POOL_SIZE];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("frequency_count_table_core: mismatch");
      $finish;
   end

   // insert/delete on the shadow table; saturated or empty keys stay put
   task automatic bump_key(input logic [KIND_W-1:0] kind, input logic [OPERAND_W-1:0] key);
      int unsigned was;
      int unsigned now;
      was = 32'(key_count[key]);
      if (kind == KIND_INSERT) begin
         if (was >= COUNT_MAX) return;
         now = was + 1;
      end else begin
         if (was == 0) return;
         now = was - 1;
      end
      key_count[key] = now[OPERAND_W-1:0];
      if (was != 0 && keys_at_count[was] != 0) keys_at_count[was]--;
      if (now != 0) keys_at_count[now]++;
   endtask

   function automatic bit freq_present(input logic [OPERAND_W-1:0] freq);
      return freq != 0 && keys_at_count[freq] != 0;
   endfunction

   function automatic bit idle_now();
      return !calm && $urandom_range(0, 99) < IDLE_PCT;
   endfunction

   // Enters just after a rising edge. Drives at the falling edge, holds until
   // the handshake, then folds the request into the shadow table.
   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic [OPERAND_W-1:0] operand,
                               input bit typed, input bit typed_present);
      bit ans;
      @(negedge clock);
      while (idle_now()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0000, operand};
      do @(posedge clock); while (!req_tready);
      case (kind)
         KIND_INSERT: begin
            n_insert++;
            bump_key(kind, operand);
         end
         KIND_DELETE: begin
            n_delete++;
            bump_key(kind, operand);
         end
         KIND_CHECK: begin
            n_check++;
            ans = typed ? typed_present : freq_present(operand);
            if (ans) n_hits++;
            pending_present = {pending_present, ans};
         end
         default: n_ignored++;
      endcase
   endtask

   // sink side stalls at random too
   always @(negedge clock) begin
      rsp_tready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
   end

   // response checker, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_present.size() == 0) begin
            $error("present: expected nothing, got %0d", rsp_tdata[0]);
            errors++;
         end else begin
            if (rsp_tdata[0] !== pending_present[0]) begin
               $error("present: expected %0d, got %0d", pending_present[0], rsp_tdata[0]);
               errors++;
            end
            void'(pending_present.pop_front());
            n_answered++;
         end
      end
   end

   initial begin
      logic [KIND_W-1:0] kind;
      logic [OPERAND_W-1:0] operand;
      int pick;
      int sent;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      calm       = 1'b0;
      errors     = 0;
      n_insert = 0; n_delete = 0; n_check = 0; n_ignored = 0;
      n_hits = 0; n_answered = 0;
      for (int i = 0; i < KEY_SPACE; i++) key_count[i] = '0;
      for (int i = 0; i <= COUNT_MAX; i++) keys_at_count[i] = 0;

      // directed plan: kind, operand, reps, typed, present
      plan = '{
         '{KIND_CHECK,  12'd0,    13'd1,    1'b1, 1'b0},  // zero frequency, empty table
         '{KIND_CHECK,  12'd1,    13'd1,    1'b1, 1'b0},
         '{KIND_CHECK,  12'd4095, 13'd1,    1'b1, 1'b0},
         '{KIND_DELETE, 12'd0,    13'd1,    1'b0, 1'b0},  // delete at zero: no-op
         '{KIND_CHECK,  12'd1,    13'd1,    1'b1, 1'b0},
         '{KIND_INSERT, 12'd0,    13'd1,    1'b0, 1'b0},
         '{KIND_CHECK,  12'd1,    13'd1,    1'b0, 1'b0},
         '{KIND_INSERT, 12'd0,    13'd1,    1'b0, 1'b0},
         '{KIND_INSERT, 12'd5,    13'd1,    1'b0, 1'b0},
         '{KIND_CHECK,  12'd2,    13'd1,    1'b0, 1'b0},
         '{KIND_CHECK,  12'd1,    13'd1,    1'b0, 1'b0},
         '{KIND_DELETE, 12'd0,    13'd1,    1'b0, 1'b0},
         '{KIND_CHECK,  12'd2,    13'd1,    1'b0, 1'b0},
         '{KIND_UNUSED, 12'd4095, 13'd1,    1'b0, 1'b0},  // dropped, no response
         '{KIND_CHECK,  12'd0,    13'd1,    1'b1, 1'b0},  // zero frequency, busy table
         '{KIND_INSERT, 12'd4095, 13'd4096, 1'b0, 1'b0},  // last one saturates
         '{KIND_CHECK,  12'd4095, 13'd1,    1'b1, 1'b1},
         '{KIND_CHECK,  12'd4094, 13'd1,    1'b1, 1'b0},
         '{KIND_DELETE, 12'd4095, 13'd1,    1'b0, 1'b0},
         '{KIND_CHECK,  12'd4095, 13'd1,    1'b1, 1'b0},
         '{KIND_CHECK,  12'd4094, 13'd1,    1'b1, 1'b1},
         '{KIND_UNUSED, 12'd0,    13'd1,    1'b0, 1'b0},
         '{KIND_INSERT, 12'hAAA,  13'd1,    1'b0, 1'b0},
         '{KIND_INSERT, 12'h555,  13'd1,    1'b0, 1'b0}
      };

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      // saturation run is long; keep it free of gaps
      for (int r = 0; r < PLAN_ROWS; r++) begin
         calm = plan[r].reps > 1;
         for (int k = 0; k < plan[r].reps; k++)
            send_request(plan[r].kind, plan[r].operand, plan[r].typed, plan[r].present);
      end
      calm = 1'b0;

      // small key pool so counts climb and collide; both key extremes in it
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++)
         key_pool[i] = OPERAND_W'($urandom_range(0, KEY_SPACE-1));

      sent = 0;
      while (sent < RANDOM_REQS) begin
         calm = sent >= 600 && sent < 900;
         pick = $urandom_range(0, 99);
         if (pick < 45) kind = KIND_INSERT;
         else if (pick < 70) kind = KIND_DELETE;
         else if (pick < 95) kind = KIND_CHECK;
         else kind = KIND_UNUSED;

         if (kind == KIND_CHECK) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) operand = OPERAND_W'($urandom_range(0, 24));
            else if (pick < 80) operand = key_count[key_pool[$urandom_range(0, POOL_SIZE-1)]];
            else operand = OPERAND_W'($urandom_range(0, COUNT_MAX));
         end else if ($urandom_range(0, 99) < 85) begin
            operand = key_pool[$urandom_range(0, POOL_SIZE-1)];
         end else begin
            operand = OPERAND_W'($urandom_range(0, KEY_SPACE-1));
         end

         send_request(kind, operand, 1'b0, 1'b0);
         if (kind != KIND_UNUSED) sent++;
      end
      calm = 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain, then give the back end time for a trailing update
      while (pending_present.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d inserts, %0d deletes, %0d checks (%0d hits), %0d dropped kinds",
               n_insert, n_delete, n_check, n_hits, n_ignored);
      $display("one key driven into saturation; %0d responses compared", n_answered);
      if (errors == 0) begin
         $display("frequency_count_table_core: match");
      end else begin
         $display("frequency_count_table_core: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire

[sim.f]
hdl/fct_pkg.sv
hdl/fct_ram.sv
hdl/fct_front.sv
hdl/fct_back.sv
hdl/frequency_count_table_core.sv
test/tb.sv
